### hdl/apaf_pkg.sv
// ----------------------------------------------------------------------------
// apaf_pkg
// Types and constants for the ADC position ASCII framer: register indexes,
// calibration constants, frame characters and the decimal digit splitter.
// ----------------------------------------------------------------------------
package apaf_pkg;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 14;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 8'd1;

  // Field widths.
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned GAIN_W   = 14;
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned PROD_W   = SAMPLE_W + GAIN_W;  // 26 bits
  localparam int unsigned SCALED_W = 13;                  // product / 10000 < 6709
  localparam int unsigned POS_W    = 14;                  // 0 .. 9999

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 14'd4513;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 12'd147;
  localparam logic [POS_W-1:0]    POS_MAX      = 14'd9999;

  // Division by 10000 as a multiply by ceil(2^40 / 10000). It is exact for
  // every dividend below 2^26.
  localparam int unsigned RECIP_SHIFT = 40;
  localparam int unsigned RECIP_W     = 27;
  localparam logic [RECIP_W-1:0] RECIP_10000 = 27'd109951163;
  localparam int unsigned MUL_W = PROD_W + RECIP_W;

  // Frame characters.
  localparam logic [7:0] CH_STX  = 8'h02;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_ETX  = 8'h03;
  localparam logic [7:0] CH_ZERO = 8'h30;

  // Byte positions within the frame.
  localparam int unsigned FRAME_LEN = 8;
  localparam int unsigned BIDX_W    = 3;
  localparam logic [BIDX_W-1:0] BYTE_STX   = 3'd0;
  localparam logic [BIDX_W-1:0] BYTE_THOU  = 3'd1;
  localparam logic [BIDX_W-1:0] BYTE_DOT   = 3'd2;
  localparam logic [BIDX_W-1:0] BYTE_HUND  = 3'd3;
  localparam logic [BIDX_W-1:0] BYTE_TENS  = 3'd4;
  localparam logic [BIDX_W-1:0] BYTE_UNITS = 3'd5;
  localparam logic [BIDX_W-1:0] BYTE_CR    = 3'd6;
  localparam logic [BIDX_W-1:0] BYTE_ETX   = 3'd7;

  typedef struct packed {
    logic [3:0]       digit;
    logic [POS_W-1:0] rem;
  } digit_split_t;

  // Leading decimal digit of v for a given place value, with the remainder.
  // v must be below ten times the place value. The nine compares are
  // independent; the largest one that holds wins.
  function automatic digit_split_t split_digit(input logic [POS_W-1:0] v,
                                               input logic [POS_W-1:0] unit);
    digit_split_t     res;
    logic [POS_W-1:0] step;
    res.digit = 4'd0;
    res.rem   = v;
    for (int k = 1; k < 10; k++) begin
      step = POS_W'(k) * unit;
      if (v >= step) begin
        res.digit = 4'(k);
        res.rem   = v - step;
      end
    end
    return res;
  endfunction

endpackage

### hdl/adc_position_ascii_framer.sv
// ----------------------------------------------------------------------------
// adc_position_ascii_framer
// Calibrates a 12-bit converter sample to a position in thousandths of a
// centimeter and sends it as an eight-byte ASCII frame.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake           Payload
// in_      in   in_tvalid/tready    tdata[11:0] sample, tdata[15:12] zero
// out_     out  out_tvalid/tready   tdata[7:0] frame_byte, tlast = last
// cfg_     in   cfg_valid/ready     cfg_index (0 gain, 1 offset), cfg_data
//
// Each sample yields eight bytes, one per cycle while out_tready is high, so
// a sample is taken once per frame at full rate; the byte serializer sets that
// pace. The first byte goes out from the frame register behind stage six.
// The six-stage calibration pipeline keeps accepting while a frame is sent.
// A stall on the output holds the frame and backs up the pipeline stage by stage.
// Reset (rst_n low, synchronous) empties the pipeline and loads gain 4513 and
// offset 147. in_tready and cfg_ready are low while reset is held; cfg_ready
// is high otherwise.

module adc_position_ascii_framer (
  input  logic        clk,
  input  logic        rst_n,
  // Input samples.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [11:0] sample, [15:12] zero
  // Output frame bytes.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] frame_byte
  output logic        out_tlast,   // last byte of the frame (ETX)
  // Configuration writes.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [apaf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apaf_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [apaf_pkg::GAIN_W-1:0]   gain_r;
  logic [apaf_pkg::OFFSET_W-1:0] offset_r;

  // Pipeline valid bits and payloads.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic en1, en2, en3, en4, en5, en6;

  logic [apaf_pkg::SAMPLE_W-1:0] sample_r;
  logic [apaf_pkg::PROD_W-1:0]   prod_r;
  logic [apaf_pkg::SCALED_W-1:0] scaled_r;
  logic [apaf_pkg::POS_W-1:0]    pos_r;
  logic [3:0]                    s5_thou_r;
  logic [apaf_pkg::POS_W-1:0]    s5_rem_r;
  logic [3:0]                    s6_thou_r, s6_hund_r;
  logic [apaf_pkg::POS_W-1:0]    s6_rem_r;

  // Frame serializer.
  logic                        fr_v_r;
  logic [apaf_pkg::BIDX_W-1:0] idx_r;
  logic [3:0]                  d_thou_r, d_hund_r, d_tens_r, d_units_r;
  logic                        fr_free;
  logic                        out_fire;

  // Combinational intermediates.
  logic [apaf_pkg::MUL_W-1:0]  recip_mul;
  logic [apaf_pkg::POS_W-1:0]  scaled_ext;
  logic [apaf_pkg::POS_W-1:0]  offset_ext;
  logic [apaf_pkg::POS_W-1:0]  pos_nxt;
  apaf_pkg::digit_split_t      thou_split, hund_split, tens_split;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= apaf_pkg::GAIN_RESET;
      offset_r <= apaf_pkg::OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == apaf_pkg::REG_GAIN) begin
        gain_r <= cfg_data[apaf_pkg::GAIN_W-1:0];
      end else if (cfg_index == apaf_pkg::REG_OFFSET) begin
        offset_r <= cfg_data[apaf_pkg::OFFSET_W-1:0];
      end
    end
  end

  // A stage may load when it is empty or its content moves on this cycle.
  assign out_fire = out_tvalid && out_tready;
  assign fr_free  = !fr_v_r || (out_fire && (idx_r == apaf_pkg::BYTE_ETX));
  assign en6      = !v6_r || fr_free;
  assign en5      = !v5_r || en6;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_tready = rst_n && en1;

  always_comb begin
    recip_mul  = apaf_pkg::MUL_W'(prod_r) * apaf_pkg::MUL_W'(apaf_pkg::RECIP_10000);
    scaled_ext = apaf_pkg::POS_W'(scaled_r);
    offset_ext = apaf_pkg::POS_W'(offset_r);
    // Saturate at zero, then cap at the largest four-digit value.
    if (scaled_ext <= offset_ext) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = scaled_ext - offset_ext;
    end
    if (pos_nxt > apaf_pkg::POS_MAX) begin
      pos_nxt = apaf_pkg::POS_MAX;
    end
    thou_split = apaf_pkg::split_digit(pos_r, apaf_pkg::POS_W'(1000));
    hund_split = apaf_pkg::split_digit(s5_rem_r, apaf_pkg::POS_W'(100));
    tens_split = apaf_pkg::split_digit(s6_rem_r, apaf_pkg::POS_W'(10));
  end

  // Valid bits and serializer control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      v5_r   <= 1'b0;
      v6_r   <= 1'b0;
      fr_v_r <= 1'b0;
      idx_r  <= apaf_pkg::BYTE_STX;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
      if (fr_free) begin
        fr_v_r <= v6_r;
        idx_r  <= apaf_pkg::BYTE_STX;
      end else if (out_fire) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // Pipeline payloads.
  always_ff @(posedge clk) begin
    if (en1) sample_r <= in_tdata[apaf_pkg::SAMPLE_W-1:0];
    if (en2) prod_r   <= apaf_pkg::PROD_W'(sample_r) * apaf_pkg::PROD_W'(gain_r);
    if (en3) scaled_r <= recip_mul[apaf_pkg::RECIP_SHIFT +: apaf_pkg::SCALED_W];
    if (en4) pos_r    <= pos_nxt;
    if (en5) begin
      s5_thou_r <= thou_split.digit;
      s5_rem_r  <= thou_split.rem;
    end
    if (en6) begin
      s6_thou_r <= s5_thou_r;
      s6_hund_r <= hund_split.digit;
      s6_rem_r  <= hund_split.rem;
    end
    if (fr_free) begin
      d_thou_r  <= s6_thou_r;
      d_hund_r  <= s6_hund_r;
      d_tens_r  <= tens_split.digit;
      d_units_r <= tens_split.rem[3:0];
    end
  end

  assign out_tvalid = fr_v_r;
  assign out_tlast  = (idx_r == apaf_pkg::BYTE_ETX);

  always_comb begin
    case (idx_r)
      apaf_pkg::BYTE_STX:   out_tdata = apaf_pkg::CH_STX;
      apaf_pkg::BYTE_THOU:  out_tdata = apaf_pkg::CH_ZERO + {4'd0, d_thou_r};
      apaf_pkg::BYTE_DOT:   out_tdata = apaf_pkg::CH_DOT;
      apaf_pkg::BYTE_HUND:  out_tdata = apaf_pkg::CH_ZERO + {4'd0, d_hund_r};
      apaf_pkg::BYTE_TENS:  out_tdata = apaf_pkg::CH_ZERO + {4'd0, d_tens_r};
      apaf_pkg::BYTE_UNITS: out_tdata = apaf_pkg::CH_ZERO + {4'd0, d_units_r};
      apaf_pkg::BYTE_CR:    out_tdata = apaf_pkg::CH_CR;
      apaf_pkg::BYTE_ETX:   out_tdata = apaf_pkg::CH_ETX;
      default:              out_tdata = apaf_pkg::CH_ETX;
    endcase
  end

`ifndef NO_ASSERTIONS
  // A frame, once started, stays on the bus until its ETX byte is taken.
  a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("frame ended before its last byte");

  // The opening byte of a frame is never flagged as the last.
  a_stx_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && idx_r == apaf_pkg::BYTE_STX |-> !out_tlast)
    else $error("STX byte flagged as last");

  // A position waiting in the last stage is not lost while the frame is busy.
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v6_r && !fr_free |=> v6_r)
    else $error("pipeline item dropped while serializer busy");

  // An accepted sample always enters the pipeline.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v1_r)
    else $error("accepted sample not captured");
`endif

endmodule
